FILE: sv/dnle_pkg.sv
package dnle_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;

    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'd46;
    localparam logic [BYTE_W-1:0] TERM_BYTE = 8'd0;

    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

endpackage

FILE: sv/dnle_ram.sv
module dnle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 62
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/dns_name_label_encoder.sv
// channel   dir  tdata            tuser             tlast
// s_axis    in   char_byte [7:0]  mode [0]          -
// m_axis    out  out_byte [7:0]   label_overflow [0] last
//
// a name character gives no result; it is written to the label ram, or dropped with the
// overflow flag set once the label is full; a dot or end-of-name request starts a flush of
// n kept characters (length byte, then each character in turn, ram read issued one byte
// ahead, then the zero terminator on end of name); input is held off during the flush
// reset clears count, overflow flag and the output register; the label ram is not cleared
// a stall on m_axis holds the flush in place; characters are still taken while the last
// result of a finished flush waits in the output register
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL = 62
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] char_byte
    input  logic              s_axis_tuser,   // [0] mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] label_overflow
);

    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TERM
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              flush_ovf_reg, flush_ovf_next;
    logic              term_reg, term_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_user_reg, m_user_next;

    logic              s_accept;
    logic              slot_free;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    dnle_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LABEL)
    ) u_label_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        rd_addr_next   = rd_addr_reg;
        flush_ovf_next = flush_ovf_reg;
        term_next      = term_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = rd_addr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if ((s_axis_tuser == MODE_END) || (s_axis_tdata == DOT_CHAR))
                    begin
                        len_next       = count_reg;
                        flush_ovf_next = ovf_reg;
                        term_next      = (s_axis_tuser == MODE_END);
                        count_next     = '0;
                        ovf_next       = 1'b0;
                        state_next     = ST_LEN;
                    end
                    else if (count_reg < CNT_W'(MAX_LABEL))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // label full: character is dropped
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(BYTE_W-CNT_W){1'b0}}, len_reg};
                    m_last_next  = !term_reg && (len_reg == '0);
                    m_user_next  = flush_ovf_reg;
                    if (len_reg != '0)
                    begin
                        ram_re       = 1'b1;
                        ram_raddr    = '0;
                        rd_addr_next = AW'(1);
                        rem_next     = len_reg;
                        state_next   = ST_DATA;
                    end
                    else
                    begin
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = ram_rdata;
                    m_last_next  = !term_reg && (rem_reg == CNT_W'(1));
                    m_user_next  = flush_ovf_reg;
                    rem_next     = rem_reg - CNT_W'(1);
                    if (rem_reg != CNT_W'(1))
                    begin
                        // fetch the next character while this one goes out
                        ram_re       = 1'b1;
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                    else
                    begin
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = TERM_BYTE;
                    m_last_next  = 1'b1;
                    m_user_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            len_reg       <= '0;
            rem_reg       <= '0;
            rd_addr_reg   <= '0;
            flush_ovf_reg <= 1'b0;
            term_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_last_reg    <= 1'b0;
            m_user_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            len_reg       <= len_next;
            rem_reg       <= rem_next;
            rd_addr_reg   <= rd_addr_next;
            flush_ovf_reg <= flush_ovf_next;
            term_reg      <= term_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            m_last_reg    <= m_last_next;
            m_user_reg    <= m_user_next;
        end
    end

endmodule

FILE: sv/dnle_checker.sv
module dnle_checker
    import dnle_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [BYTE_W-1:0] s_axis_tdata,
    input logic              s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [BYTE_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // a result that is not the last one means a flush is under way
    a_busy_mid_flush: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a flush");

    // a dot or end-of-name request always starts a flush
    a_flush_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && ((s_axis_tuser == MODE_END) || (s_axis_tdata == DOT_CHAR))
        |=> !s_axis_tready)
        else $error("flush request did not hold off input");

endmodule

bind dns_name_label_encoder dnle_checker u_dnle_checker (.*);

FILE: test/tb_top.sv
module tb_top;
    import dnle_pkg::*;

    localparam int LABEL_CAP      = 62;
    localparam int RANDOM_ITEMS   = 40;
    localparam int NOISE_ITEMS    = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              ovf;
    } wire_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tuser = MODE_CHAR;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b1;
    logic [BYTE_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    // predicted encoder state
    logic [BYTE_W-1:0] label_buf [LABEL_CAP];
    logic [CNT_W-1:0]  label_len = '0;
    logic              label_dropped = 1'b0;
    wire_byte_t        expected_bytes [$];

    bit idle_on = 1'b1;
    int sink_hold = 0;
    int error_count = 0;
    int items_sent = 0;
    int names_ended = 0;
    int bytes_checked = 0;
    int overflow_bytes = 0;
    int quiet_cycles = 0;

    dns_name_label_encoder #(
        .MAX_LABEL(LABEL_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // length byte then the kept characters, then the label is cleared
    task automatic flush_label(input bit ends_request);
        wire_byte_t wb;
        wb.out_byte = BYTE_W'(label_len);
        wb.last     = ends_request && (label_len == 0);
        wb.ovf      = label_dropped;
        expected_bytes.push_back(wb);
        for (int i = 0; i < int'(label_len); i++)
        begin
            wb.out_byte = label_buf[i];
            wb.last     = ends_request && (i == int'(label_len) - 1);
            expected_bytes.push_back(wb);
        end
        label_len     = '0;
        label_dropped = 1'b0;
    endtask

    task automatic encode_request(input logic mode, input logic [BYTE_W-1:0] ch);
        wire_byte_t wb;
        if (mode == MODE_END)
        begin
            flush_label(1'b0);
            wb.out_byte = TERM_BYTE;
            wb.last     = 1'b1;
            wb.ovf      = 1'b0;
            expected_bytes.push_back(wb);
            names_ended++;
        end
        else if (ch == DOT_CHAR)
        begin
            flush_label(1'b1);
        end
        else if (int'(label_len) < LABEL_CAP)
        begin
            label_buf[label_len] = ch;
            label_len            = label_len + CNT_W'(1);
        end
        else
        begin
            label_dropped = 1'b1;
        end
    endtask

    // called right after an accepting edge or at the start; returns at the accepting edge
    task automatic send_request(input logic mode, input logic [BYTE_W-1:0] ch);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encode_request(mode, ch);
        items_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_label_char();
        logic [BYTE_W-1:0] ch;
        ch = BYTE_W'($urandom_range(0, 255));
        while (ch == DOT_CHAR)
            ch = BYTE_W'($urandom_range(0, 255));
        return ch;
    endfunction

    task automatic send_label(input int len);
        for (int i = 0; i < len; i++)
            send_request(MODE_CHAR, rand_label_char());
    endtask

    task automatic send_random_name();
        int nlabels;
        int pick;
        nlabels = $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0)
            send_request(MODE_CHAR, DOT_CHAR);
        for (int l = 0; l < nlabels; l++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_label($urandom_range(55, 70));
            else if (pick < 3)
                send_label(0);
            else
                send_label($urandom_range(1, 12));
            // broken sequence now and then
            if ($urandom_range(0, 11) == 0)
                send_request(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
            if (l + 1 < nlabels || $urandom_range(0, 5) == 0)
                send_request(MODE_CHAR, DOT_CHAR);
        end
        send_request(MODE_END, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_directed_cases();
        send_request(MODE_END, 8'h00);          // empty name
        send_request(MODE_CHAR, DOT_CHAR);      // leading dot, then end right after a dot
        send_request(MODE_END, 8'hFF);
        send_request(MODE_CHAR, 8'h00);         // zero character is kept
        send_request(MODE_CHAR, 8'hFF);
        send_request(MODE_CHAR, DOT_CHAR);
        send_request(MODE_CHAR, 8'h2F);         // neighbours of the dot
        send_request(MODE_CHAR, 8'h2D);
        send_request(MODE_CHAR, DOT_CHAR);
        send_request(MODE_CHAR, DOT_CHAR);      // two dots in a row
        send_request(MODE_END, 8'hAA);
        send_request(MODE_CHAR, 8'h77);
        send_request(MODE_END, DOT_CHAR);       // char field ignored on end of name
        send_request(MODE_CHAR, 8'h55);
        send_request(MODE_CHAR, DOT_CHAR);
        send_request(MODE_END, 8'h00);
    endtask

    task automatic test_label_capacity();
        send_label(LABEL_CAP);                  // full label, nothing dropped
        send_request(MODE_CHAR, DOT_CHAR);
        send_label(LABEL_CAP + 1);              // one character dropped, flushed by end of name
        send_request(MODE_END, 8'h00);
        send_label(2);                          // overflow flag must be clear again
        send_request(MODE_CHAR, DOT_CHAR);
        send_request(MODE_END, 8'h00);
    endtask

    task automatic test_noise();
        logic mode;
        logic [BYTE_W-1:0] ch;
        for (int i = 0; i < NOISE_ITEMS; i++)
        begin
            mode = ($urandom_range(0, 5) == 0) ? MODE_END : MODE_CHAR;
            ch   = ($urandom_range(0, 4) == 0) ? DOT_CHAR : BYTE_W'($urandom_range(0, 255));
            send_request(mode, ch);
        end
        send_request(MODE_END, 8'h00);
    endtask

    task automatic test_random_names();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at)
            send_random_name();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        for (int n = 0; n < 3; n++)
            send_random_name();
        send_label(4);
        send_request(MODE_CHAR, DOT_CHAR);
        send_request(MODE_END, 8'h00);
    endtask

    always @(negedge clk)
    begin
        if (!idle_on)
        begin
            sink_hold = 0;
            m_axis_tready <= 1'b1;
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            sink_hold = $urandom_range(1, 9) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        wire_byte_t wb;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_checked++;
            if (m_axis_tuser === 1'b1)
                overflow_bytes++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
            end
            else
            begin
                wb = expected_bytes.pop_front();
                if (m_axis_tdata !== wb.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_axis_tdata, wb.out_byte));
                if (m_axis_tlast !== wb.last)
                    report_mismatch($sformatf("last %b, want %b on byte %02h",
                                              m_axis_tlast, wb.last, wb.out_byte));
                if (m_axis_tuser !== wb.ovf)
                    report_mismatch($sformatf("label_overflow %b, want %b on byte %02h",
                                              m_axis_tuser, wb.ovf, wb.out_byte));
            end
        end
    end

    // ends the run when nothing moves on either side for too long
    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request or byte moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_label_capacity();
        test_noise();
        test_random_names();
        test_back_to_back();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests forming %0d names, checked %0d wire bytes",
                 items_sent, names_ended, bytes_checked);
        $display("%0d bytes carried the overflow flag, %0d mismatches",
                 overflow_bytes, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
